FILE: src/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the frontier cell detector: register indexes,
// field widths, reset values and the per-cell class tag.
// ----------------------------------------------------------------------------
package fcd_pkg;

  // Field widths
  localparam int OCC_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int THR_W      = 7;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CLS_W      = 2;

  // Default grid limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD = 2'd2;

  // Register reset values and size floor
  localparam int               SIZE_RST  = 1024;
  localparam int               SIZE_MIN  = 3;
  localparam logic [THR_W-1:0] THR_RST   = 7'd40;

  // Occupancy code for an unknown cell
  localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;

  // Class bit positions: bit 0 unknown, bit 1 free
  localparam int CLS_UNKNOWN_BIT = 0;
  localparam int CLS_FREE_BIT    = 1;

  // Tag of one accepted cell, carried into the stencil stage
  typedef struct packed {
    logic             emit;   // cell completes a 3x3 window
    logic             last;   // centre is the last interior cell
    logic [CLS_W-1:0] cls;    // class of the new cell
  } cell_tag_t;

endpackage

FILE: src/fcd_line_buf.sv
// ----------------------------------------------------------------------------
// fcd_line_buf
// Two-row line buffer in one memory: each entry holds the classes of the
// older row (upper bits) and the newer row (lower bits) at one column.
// Registered read with write-to-read forwarding on the same address.
// ----------------------------------------------------------------------------
module fcd_line_buf
  import fcd_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [2*CLS_W-1:0]         rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [2*CLS_W-1:0]         wr_data_i
);

  logic [2*CLS_W-1:0] mem [DEPTH];
  logic [2*CLS_W-1:0] rd_data_q;

  // Write the updated column, read the next one; forward a same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/fcd_raster_ctr.sv
// ----------------------------------------------------------------------------
// fcd_raster_ctr
// Configuration registers and raster position counters. Gives the position
// of the incoming cell, its class and its window flags.
// ----------------------------------------------------------------------------
module fcd_raster_ctr
  import fcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]           cfg_data_i,
  input  logic                            step_i,
  input  logic signed [OCC_W-1:0]         occupancy_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    x_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]   y_o,
  output cell_tag_t                       tag_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SIZE_RST;
  localparam int H_RST = (SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RST;

  logic [WW-1:0]    width_q, width_d;
  logic [HW-1:0]    height_q, height_d;
  logic [THR_W-1:0] thr_q, thr_d;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  logic          col_wrap, row_wrap, x_end, y_end;
  logic [HW-1:0] row_inc, y_inc;
  logic [WW-1:0] x_inc;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  logic          unknown, free;

  // Clamp sizes on write, decode the register index
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thr_d    = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH: begin
          if (cfg_data_i < CFG_DATA_W'(SIZE_MIN)) begin
            width_d = WW'(SIZE_MIN);
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(cfg_data_i);
          end
        end
        CFG_GRID_HEIGHT: begin
          if (cfg_data_i < CFG_DATA_W'(SIZE_MIN)) begin
            height_d = HW'(SIZE_MIN);
          end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
            height_d = HW'(MAX_HEIGHT);
          end else begin
            height_d = HW'(cfg_data_i);
          end
        end
        CFG_FREE_THRESHOLD: begin
          thr_d = cfg_data_i[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Position of the incoming cell, ending a row early after a size change
  always_comb begin
    col_wrap = (WW'(col_q) >= width_q);
    x        = col_wrap ? '0 : col_q;
    row_inc  = col_wrap ? (HW'(row_q) + HW'(1)) : HW'(row_q);
    row_wrap = (row_inc >= height_q);
    y        = row_wrap ? '0 : row_inc[RW-1:0];
  end

  // Advance past the incoming cell
  always_comb begin
    x_inc = WW'(x) + WW'(1);
    y_inc = HW'(y) + HW'(1);
    x_end = (x_inc >= width_q);
    y_end = (y_inc >= height_q);
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (x_end) begin
        col_d = '0;
        row_d = y_end ? '0 : y_inc[RW-1:0];
      end else begin
        col_d = x_inc[CW-1:0];
        row_d = y;
      end
    end
  end

  // Classify the incoming cell
  always_comb begin
    unknown = (occupancy_i == OCC_UNKNOWN);
    free    = !occupancy_i[OCC_W-1] && (occupancy_i[OCC_W-2:0] <= thr_q);
    tag_o.cls                  = '0;
    tag_o.cls[CLS_UNKNOWN_BIT] = unknown;
    tag_o.cls[CLS_FREE_BIT]    = free;
    tag_o.emit = (x >= CW'(2)) && (y >= RW'(2));
    tag_o.last = (x_inc == width_q) && (y_inc == height_q);
  end

  assign x_o = x;
  assign y_o = y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RST);
      height_q <= HW'(H_RST);
      thr_q    <= THR_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      thr_q    <= thr_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

FILE: src/fcd_stencil.sv
// ----------------------------------------------------------------------------
// fcd_stencil
// Stencil stage and result register. Joins the line buffer read with the
// new cell, writes the column back, slides the 3x3 window and forms the
// frontier result.
// ----------------------------------------------------------------------------
module fcd_stencil
  import fcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    x_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]   y_i,
  input  cell_tag_t                       tag_i,
  input  logic [2*CLS_W-1:0]              rows_i,
  output logic                            in_ready_o,
  output logic                            wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr_o,
  output logic [2*CLS_W-1:0]              wr_data_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_W-1:0]              cell_x_o,
  output logic [COORD_W-1:0]              cell_y_o,
  output logic                            is_frontier_o,
  output logic                            frame_last_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int XW  = (CW > COORD_W) ? CW : COORD_W;
  localparam int YW  = (RW > COORD_W) ? RW : COORD_W;
  localparam int COLW = 3 * CLS_W;

  // Unknown bit of each row in a column word, and of top and bottom only
  localparam logic [COLW-1:0] UNK_ALL   = 6'b01_01_01;
  localparam logic [COLW-1:0] UNK_EDGES = 6'b01_00_01;

  logic            s1_valid_q, s1_valid_d;
  logic [CW-1:0]   s1_x_q;
  logic [RW-1:0]   s1_y_q;
  cell_tag_t       s1_tag_q;
  logic [2*COLW-1:0] win_q, win_d;

  logic              out_valid_q, out_valid_d;
  logic [COORD_W-1:0] cell_x_q, cell_y_q;
  logic              frontier_q, last_q;

  logic              s1_go;
  logic [COLW-1:0]   col_word, left, centre;
  logic              any_unknown, frontier;
  logic [XW-1:0]     x_m1;
  logic [YW-1:0]     y_m1;

  // Move the stage on unless its result is blocked by a full output
  assign s1_go      = s1_valid_q && (!s1_tag_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  // Build the window: top = older row, middle = newer row, bottom = new cell
  always_comb begin
    col_word    = {rows_i, s1_tag_q.cls};
    left        = win_q[2*COLW-1:COLW];
    centre      = win_q[COLW-1:0];
    any_unknown = (((left | col_word) & UNK_ALL) != '0) || ((centre & UNK_EDGES) != '0);
    frontier    = centre[CLS_W + CLS_FREE_BIT] && any_unknown;
    win_d       = s1_go ? {centre, col_word} : win_q;
    x_m1        = XW'(s1_x_q) - XW'(1);
    y_m1        = YW'(s1_y_q) - YW'(1);
  end

  // Shift the column down one row in the line buffer
  assign wr_en_o   = s1_go;
  assign wr_addr_o = s1_x_q;
  assign wr_data_o = {rows_i[CLS_W-1:0], s1_tag_q.cls};

  // Stage and output occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_go && s1_tag_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  // Capture the accepted cell
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_x_q   <= x_i;
      s1_y_q   <= y_i;
      s1_tag_q <= tag_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (s1_go && s1_tag_q.emit) begin
      cell_x_q   <= x_m1[COORD_W-1:0];
      cell_y_q   <= y_m1[COORD_W-1:0];
      frontier_q <= frontier;
      last_q     <= s1_tag_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_x_o      = cell_x_q;
  assign cell_y_o      = cell_y_q;
  assign is_frontier_o = frontier_q;
  assign frame_last_o  = last_q;

endmodule

FILE: src/frontier_cell_detector_unit.sv
// An accepted cell passes through the stencil stage, then the result register.
// Throughput: one cell per cycle unless output is blocked; the line buffer
// does one read and one write of a column each cycle, with forwarding
// between them.
// Output backpressure stalls input only once the stencil stage is full.
// Reset clears counters, registers, window and valids; the line buffer is
// not cleared and takes no clearing pass.
// ----------------------------------------------------------------------------
// frontier_cell_detector_unit
// Frontier detection over a raster stream of occupancy cells: a 3x3
// stencil fed by a two-row line buffer, one result per interior cell.
// ----------------------------------------------------------------------------
module frontier_cell_detector_unit
  import fcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [OCC_W-1:0]  occupancy_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [COORD_W-1:0]       cell_x_o,
  output logic [COORD_W-1:0]       cell_y_o,
  output logic                     is_frontier_o,
  output logic                     frame_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic               acc;
  logic [CW-1:0]      x, wr_addr;
  logic [RW-1:0]      y;
  cell_tag_t          tag;
  logic [2*CLS_W-1:0] rows, wr_data;
  logic               wr_en;

  // Accept a cell transaction
  assign acc = in_valid_i && in_ready_o;

  fcd_raster_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (acc),
    .occupancy_i (occupancy_i),
    .x_o         (x),
    .y_o         (y),
    .tag_o       (tag)
  );

  fcd_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_buf (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (x),
    .rd_data_o (rows),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  fcd_stencil #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stencil (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .x_i           (x),
    .y_i           (y),
    .tag_i         (tag),
    .rows_i        (rows),
    .in_ready_o    (in_ready_o),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .is_frontier_o (is_frontier_o),
    .frame_last_o  (frame_last_o)
  );

endmodule
